// File: rtl/rlps_pkg.sv
// Shared types, constants and helpers for the RGB LED pattern sequencer.
package rlps_pkg;

  localparam int NUM_MODES    = 4;
  localparam int MAX_FRAMES   = 32;
  localparam int NUM_PATTERNS = 4;
  localparam int PAT_W        = 57;
  localparam int CFG_IDX_W    = 2;
  localparam int DUR_W        = 32;
  localparam int LEN_W        = 6;
  localparam int MS_W         = 16;
  localparam int LENMS_W      = LEN_W + MS_W;

  localparam logic [DUR_W-1:0] DUR_UNLIMITED = '1;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_START,
    ACT_REPEAT,
    ACT_STOP
  } action_t;

  typedef struct packed {
    logic [2:0]       color;
    logic [MS_W-1:0]  frame_ms;
    logic [LEN_W-1:0] length;
    logic [31:0]      slots;
  } pattern_t;

  localparam pattern_t PAT_RESET [NUM_PATTERNS] = '{
    '{3'd2, 16'd125, 6'd8, 32'hA000_0000},
    '{3'd1, 16'd125, 6'd8, 32'hA000_0000},
    '{3'd4, 16'd125, 6'd8, 32'hA000_0000},
    '{3'd7, 16'd125, 6'd8, 32'h8800_0000}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_LEN,
    ST_MUL_COUNT,
    ST_EXEC
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DEC_MS,
    OP_NEXT_FRAME,
    OP_REPEAT,
    OP_SWITCH,
    OP_GO_IDLE,
    OP_STOP_END,
    OP_START_NOW,
    OP_START_PEND,
    OP_CLEAR
  } exec_op_t;

  typedef struct packed {
    logic     capture;
    logic     mul_len;
    logic     mul_count;
    logic     exec;
    exec_op_t op;
    logic     use_product;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    mode_ok;
    logic    playing;
    logic    ms_gt1;
    logic    next_in_range;
    logic    latest_valid;
    logic    latest_is_new;
    logic    remaining_nz;
  } dp_status_t;

  // Clamp the length field to the frame limit.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(MAX_FRAMES);
    return (raw > lim) ? lim : raw;
  endfunction

endpackage

// File: rtl/rlps_if.sv
// Item and result channel interfaces for the RGB LED pattern sequencer.
interface rlps_item_if;
  import rlps_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [1:0]        mode;
  logic [DUR_W-1:0]  amount;

  modport source (output valid, output action, output mode, output amount, input ready);
  modport sink   (input valid, input action, input mode, input amount, output ready);
endinterface

interface rlps_result_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic       busy_res;
  logic [1:0] playing_mode;

  modport source (output valid, output red_on, output green_on, output blue_on,
                  output busy_res, output playing_mode, input ready);
  modport sink   (input valid, input red_on, input green_on, input blue_on,
                  input busy_res, input playing_mode, output ready);
endinterface

// File: rtl/rgb_led_pattern_sequencer_core.sv
// Top level of the RGB LED pattern sequencer: controller plus datapath.
//
//   channel  | dir | payload                                        | handshake
//   ---------+-----+------------------------------------------------+-----------
//   item     | in  | action, mode, amount                           | valid/ready
//   result   | out | red_on, green_on, blue_on, busy_res, playing_mode | valid/ready
//   cfg      | in  | cfg_index, cfg_data                            | cfg_write_en
//
// Each word passes through capture, length x frame-time multiply, count multiply,
// and the sequencer update, which loads the result register.
// The next word is taken in the cycle after the update if the result register
// is empty or being read, so a stalled result holds off only the following word.
// Synchronous reset restores the default patterns and idles the sequencer at once.
module rgb_led_pattern_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  rlps_item_if.sink                       item,
  rlps_result_if.source                   result,
  input  logic                            cfg_write_en,
  input  logic [rlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlps_pkg::PAT_W-1:0]      cfg_data
);
  import rlps_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rlps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  rlps_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (item.action),
    .mode         (item.mode),
    .amount       (item.amount),
    .cmd          (cmd),
    .status       (status),
    .red_on       (result.red_on),
    .green_on     (result.green_on),
    .blue_on      (result.blue_on),
    .busy_res     (result.busy_res),
    .playing_mode (result.playing_mode)
  );

endmodule

// File: rtl/rlps_ctrl.sv
// Sequencing state machine: capture, two multiply steps, update, result hold.
module rlps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  rlps_pkg::dp_status_t  status,
  output rlps_pkg::ctrl_cmd_t   cmd
);
  import rlps_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == ST_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EXEC) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept) state_next = ST_MUL_LEN;
      ST_MUL_LEN:   state_next = ST_MUL_COUNT;
      ST_MUL_COUNT: state_next = ST_EXEC;
      ST_EXEC:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.op          = OP_NOP;
    cmd.capture     = accept;
    cmd.mul_len     = (state == ST_MUL_LEN);
    cmd.mul_count   = (state == ST_MUL_COUNT);
    cmd.exec        = (state == ST_EXEC);
    cmd.use_product = (status.action == ACT_REPEAT);
    if (state == ST_EXEC) begin
      unique case (status.action) inside
        ACT_TICK: begin
          if (status.playing) begin
            if (status.ms_gt1) begin
              cmd.op = OP_DEC_MS;
            end else if (status.next_in_range) begin
              cmd.op = OP_NEXT_FRAME;
            end else if (!status.latest_valid || status.latest_is_new) begin
              // pattern end: a newer start takes over, or go idle
              cmd.op = status.latest_valid ? OP_SWITCH : OP_GO_IDLE;
            end else if (status.remaining_nz) begin
              cmd.op = OP_REPEAT;
            end else begin
              cmd.op = OP_STOP_END;
            end
          end
        end
        ACT_START, ACT_REPEAT: begin
          if (status.mode_ok) begin
            cmd.op = status.playing ? OP_START_PEND : OP_START_NOW;
          end
        end
        ACT_STOP: cmd.op = OP_CLEAR;
        default:  cmd.op = OP_NOP;
      endcase
    end
  end

  a_exec_gives_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> result_valid)
    else $error("result word not raised after update");

  a_word_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_EXEC)
    else $error("result word raised outside update");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MUL_LEN && !item_ready)
    else $error("accepted word did not enter the multiply step");

endmodule

// File: rtl/rlps_dp.sv
// Datapath: pattern registers, sequencer state, duration multiply and result register.
module rlps_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [rlps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlps_pkg::PAT_W-1:0]        cfg_data,
  input  logic [1:0]                        action,
  input  logic [1:0]                        mode,
  input  logic [rlps_pkg::DUR_W-1:0]        amount,
  input  rlps_pkg::ctrl_cmd_t               cmd,
  output rlps_pkg::dp_status_t              status,
  output logic                              red_on,
  output logic                              green_on,
  output logic                              blue_on,
  output logic                              busy_res,
  output logic [1:0]                        playing_mode
);
  import rlps_pkg::*;

  pattern_t pat_reg [NUM_PATTERNS];

  // captured word
  action_t          item_action;
  logic [1:0]       item_mode;
  logic [DUR_W-1:0] item_amount;

  logic [LENMS_W-1:0] lenms;
  logic [DUR_W-1:0]   prod;

  pattern_t         active_pat;
  logic             playing;
  logic [1:0]       current_mode;
  logic [DUR_W-1:0] remaining;
  logic [LEN_W-1:0] frame_index;
  logic [MS_W-1:0]  frame_ms_left;
  logic             latest_valid;
  logic             latest_is_new;
  logic [1:0]       latest_mode;
  logic [DUR_W-1:0] latest_duration;
  logic [2:0]       led_levels;

  pattern_t         active_pat_next;
  logic             playing_next;
  logic [1:0]       current_mode_next;
  logic [DUR_W-1:0] remaining_next;
  logic [LEN_W-1:0] frame_index_next;
  logic [MS_W-1:0]  frame_ms_left_next;
  logic             latest_valid_next;
  logic             latest_is_new_next;
  logic [1:0]       latest_mode_next;
  logic [DUR_W-1:0] latest_duration_next;
  logic [2:0]       led_levels_next;

  logic [1:0]       rd_addr;
  pattern_t         sel_pat;
  logic [DUR_W-1:0] start_dur;
  logic [LEN_W-1:0] fi_inc;

  // frame load unit
  pattern_t         ld_pat;
  logic [LEN_W-1:0] ld_fi;
  logic [DUR_W-1:0] ld_rem;
  logic [LEN_W-1:0] ld_len;
  logic             ld_in;
  logic [2:0]       ld_led;
  logic [MS_W-1:0]  ld_ms;
  logic [DUR_W-1:0] ld_rem_out;
  logic [DUR_W-1:0] ms_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        pat_reg[i] <= PAT_RESET[i];
      end
    end else if (cfg_write_en) begin
      pat_reg[cfg_index] <= pattern_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action <= action_t'(action);
      item_mode   <= mode;
      item_amount <= amount;
    end
    if (cmd.mul_len) begin
      lenms <= LENMS_W'(sel_pat.length) * LENMS_W'(sel_pat.frame_ms);
    end
    if (cmd.mul_count) begin
      prod <= DUR_W'(lenms) * item_amount;
    end
  end

  assign rd_addr   = (cmd.op == OP_SWITCH) ? latest_mode : item_mode;
  assign sel_pat   = pat_reg[rd_addr];
  assign start_dur = cmd.use_product ? prod : item_amount;
  assign fi_inc    = frame_index + LEN_W'(1);

  always_comb begin
    ld_pat = active_pat;
    ld_fi  = '0;
    ld_rem = remaining;
    case (cmd.op)
      OP_NEXT_FRAME: ld_fi = fi_inc;
      OP_SWITCH: begin
        ld_pat = sel_pat;
        ld_rem = latest_duration;
      end
      OP_START_NOW: begin
        ld_pat = sel_pat;
        ld_rem = start_dur;
      end
      default: ;
    endcase
  end

  always_comb begin
    ld_len     = eff_len(ld_pat.length);
    ld_in      = ld_fi < ld_len;
    ms_ext     = DUR_W'(ld_pat.frame_ms);
    ld_rem_out = ld_rem;
    if (ld_in) begin
      ld_led = ld_pat.slots[~ld_fi[4:0]] ? ld_pat.color : 3'b000;
      ld_ms  = (ld_pat.frame_ms != '0) ? ld_pat.frame_ms : MS_W'(1);
      // saturate at zero, leave unlimited alone
      if (ld_rem != DUR_UNLIMITED && ld_rem != '0) begin
        ld_rem_out = (ld_rem > ms_ext) ? ld_rem - ms_ext : '0;
      end
    end else begin
      ld_led = 3'b000;
      ld_ms  = MS_W'(1);
    end
  end

  always_comb begin
    active_pat_next      = active_pat;
    playing_next         = playing;
    current_mode_next    = current_mode;
    remaining_next       = remaining;
    frame_index_next     = frame_index;
    frame_ms_left_next   = frame_ms_left;
    latest_valid_next    = latest_valid;
    latest_is_new_next   = latest_is_new;
    latest_mode_next     = latest_mode;
    latest_duration_next = latest_duration;
    led_levels_next      = led_levels;
    case (cmd.op)
      OP_DEC_MS: frame_ms_left_next = frame_ms_left - MS_W'(1);
      OP_NEXT_FRAME, OP_REPEAT: begin
        frame_index_next   = ld_fi;
        led_levels_next    = ld_led;
        frame_ms_left_next = ld_ms;
        remaining_next     = ld_rem_out;
      end
      OP_SWITCH: begin
        current_mode_next  = latest_mode;
        active_pat_next    = sel_pat;
        latest_is_new_next = 1'b0;
        frame_index_next   = '0;
        led_levels_next    = ld_led;
        frame_ms_left_next = ld_ms;
        remaining_next     = ld_rem_out;
      end
      OP_GO_IDLE, OP_STOP_END: begin
        playing_next       = 1'b0;
        led_levels_next    = 3'b000;
        frame_index_next   = '0;
        frame_ms_left_next = '0;
        if (cmd.op == OP_STOP_END) begin
          latest_valid_next = 1'b0;
        end
      end
      OP_START_NOW: begin
        latest_mode_next     = item_mode;
        latest_duration_next = start_dur;
        latest_valid_next    = 1'b1;
        latest_is_new_next   = 1'b0;
        playing_next         = 1'b1;
        current_mode_next    = item_mode;
        active_pat_next      = sel_pat;
        frame_index_next     = '0;
        led_levels_next      = ld_led;
        frame_ms_left_next   = ld_ms;
        remaining_next       = ld_rem_out;
      end
      OP_START_PEND: begin
        latest_mode_next     = item_mode;
        latest_duration_next = start_dur;
        latest_valid_next    = 1'b1;
        latest_is_new_next   = 1'b1;
      end
      OP_CLEAR: latest_valid_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_pat      <= '0;
      playing         <= 1'b0;
      current_mode    <= '0;
      remaining       <= '0;
      frame_index     <= '0;
      frame_ms_left   <= '0;
      latest_valid    <= 1'b0;
      latest_is_new   <= 1'b0;
      latest_mode     <= '0;
      latest_duration <= '0;
      led_levels      <= 3'b000;
    end else if (cmd.exec) begin
      active_pat      <= active_pat_next;
      playing         <= playing_next;
      current_mode    <= current_mode_next;
      remaining       <= remaining_next;
      frame_index     <= frame_index_next;
      frame_ms_left   <= frame_ms_left_next;
      latest_valid    <= latest_valid_next;
      latest_is_new   <= latest_is_new_next;
      latest_mode     <= latest_mode_next;
      latest_duration <= latest_duration_next;
      led_levels      <= led_levels_next;
    end
  end

  // result word holds the state after the update
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      red_on       <= led_levels_next[0];
      green_on     <= led_levels_next[1];
      blue_on      <= led_levels_next[2];
      busy_res     <= playing_next;
      playing_mode <= playing_next ? current_mode_next : 2'd0;
    end
  end

  always_comb begin
    status               = '0;
    status.action        = item_action;
    status.mode_ok       = int'(item_mode) < NUM_MODES;
    status.playing       = playing;
    status.ms_gt1        = frame_ms_left > MS_W'(1);
    status.next_in_range = fi_inc < eff_len(active_pat.length);
    status.latest_valid  = latest_valid;
    status.latest_is_new = latest_is_new;
    status.remaining_nz  = remaining != '0;
  end

  a_idle_parked: assert property (@(posedge clk) disable iff (rst)
    !playing |-> frame_index == '0 && frame_ms_left == '0)
    else $error("frame position not parked while idle");

  a_play_has_time: assert property (@(posedge clk) disable iff (rst)
    playing |-> frame_ms_left != '0)
    else $error("playing frame with no time left");

  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    !playing |-> led_levels == 3'b000)
    else $error("LEDs lit while idle");

endmodule
